/* rtl/core/regex_postfix_to_nfa_builder_unit_assert.svh */
// Assertion macros shared by the NFA builder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef REGEX_POSTFIX_TO_NFA_BUILDER_UNIT_ASSERT_SVH
`define REGEX_POSTFIX_TO_NFA_BUILDER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RNFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RNFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RNFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define RNFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/rnfa_pkg.sv */
// Types and constants for the postfix-regex to NFA builder.
// No dependencies; imported by every module of the block.
package rnfa_pkg;

  localparam int ST_W    = 8;
  localparam int SYM_W   = 8;
  localparam int MAX_RES = 5;
  localparam int RCNT_W  = 3;

  typedef enum logic [1:0] {
    OP_SYMBOL = 2'd0,
    OP_STAR   = 2'd1,
    OP_CONCAT = 2'd2,
    OP_UNION  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_UNDERFLOW = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_STATES    = 2'd2,
    ERR_LEFTOVER  = 2'd3
  } err_t;

  typedef struct packed {
    op_t              operation;
    logic [SYM_W-1:0] symbol_code;
    logic             end_of_expression;
  } in_t;

  typedef struct packed {
    kind_t            result_kind;
    logic [ST_W-1:0]  from_state;
    logic [ST_W-1:0]  to_state;
    logic             is_epsilon;
    logic [SYM_W-1:0] edge_symbol;
    err_t             error_code;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [ST_W-1:0] start_st;
    logic [ST_W-1:0] end_st;
  } frag_t;

  typedef struct packed {
    logic                    load;
    logic [RCNT_W-1:0]       cnt;
    out_t [MAX_RES-1:0]      res;
  } batch_t;

endpackage

/* rtl/core/rnfa_in_buf.sv */
// Two-entry input queue for token beats.
// Depends on rnfa_pkg; ready is decoded from the registered entry count alone.
module rnfa_in_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rnfa_pkg::in_t in_data,
  output logic          head_valid,
  output rnfa_pkg::in_t head_data,
  input  logic          head_take
);
  import rnfa_pkg::*;

  in_t        ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = ent_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = head_take && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

/* rtl/core/rnfa_core.sv */
// Thompson construction step: fragment stack, state counter, result batch.
// Depends on rnfa_pkg and the assertion macro header.
`include "regex_postfix_to_nfa_builder_unit_assert.svh"

module rnfa_core #(
  parameter int STACK_DEPTH = 32,
  parameter int STATE_LIMIT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  rnfa_pkg::in_t    head_data,
  output logic             head_take,
  input  logic             load_ok,
  output rnfa_pkg::batch_t batch
);
  import rnfa_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(STATE_LIMIT + 1);

  frag_t             mem [STACK_DEPTH];
  frag_t             t0_r, t1_r, t2_r;
  frag_t             t0_nxt, t1_nxt, t2_nxt;
  logic [LW-1:0]     level_r, level_nxt, lvl_new;
  logic [NW-1:0]     next_r, next_nxt;
  logic              take, t2_load, wr_en, rd_ok;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [ST_W-1:0]   n1, n2;
  frag_t             fa, fb, top;
  logic              under, over, exhaust;
  op_t               op;
  out_t [MAX_RES-1:0] res;
  logic [RCNT_W-1:0] cnt;

  function automatic out_t mk_edge(logic [ST_W-1:0] f, logic [ST_W-1:0] t,
                                   logic eps, logic [SYM_W-1:0] s);
    out_t r;
    r             = '0;
    r.result_kind = KIND_EDGE;
    r.from_state  = f;
    r.to_state    = t;
    r.is_epsilon  = eps;
    r.edge_symbol = s;
    return r;
  endfunction

  function automatic out_t mk_err(err_t c);
    out_t r;
    r             = '0;
    r.result_kind = KIND_ERROR;
    r.error_code  = c;
    return r;
  endfunction

  function automatic out_t mk_done(frag_t f);
    out_t r;
    r             = '0;
    r.result_kind = KIND_DONE;
    r.from_state  = f.start_st;
    r.to_state    = f.end_st;
    return r;
  endfunction

  assign take       = head_valid && load_ok;
  assign head_take  = take;
  assign batch.load = take;
  assign batch.cnt  = cnt;
  assign batch.res  = res;

  always_comb begin
    op      = head_data.operation;
    n1      = ST_W'(next_r);
    n2      = n1 + ST_W'(1);
    fa      = (op == OP_STAR) ? t0_r : t1_r;
    fb      = t0_r;
    under   = ((op == OP_STAR) && (level_r == '0)) ||
              (((op == OP_CONCAT) || (op == OP_UNION)) && (level_r < LW'(2)));
    over    = (op == OP_SYMBOL) && (level_r == LW'(STACK_DEPTH));
    exhaust = (op != OP_CONCAT) && (next_r > NW'(STATE_LIMIT - 2));
    rd_ok   = (int'(level_r) >= 4);
    rd_addr = AW'(int'(level_r) - 4);

    res       = '0;
    cnt       = '0;
    level_nxt = level_r;
    lvl_new   = level_r;
    next_nxt  = next_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    t2_load   = 1'b0;
    wr_en     = 1'b0;
    top       = t0_r;

    if (under || over || exhaust) begin
      res[0]    = mk_err(under ? ERR_UNDERFLOW : (over ? ERR_OVERFLOW : ERR_STATES));
      cnt       = RCNT_W'(1);
      level_nxt = '0;
      next_nxt  = '0;
    end else begin
      if (op != OP_CONCAT) begin
        next_nxt = next_r + NW'(2);
      end
      unique case (op)
        OP_SYMBOL: begin
          res[0]  = mk_edge(n1, n2, 1'b0, head_data.symbol_code);
          cnt     = RCNT_W'(1);
          top     = '{start_st: n1, end_st: n2};
          lvl_new = level_r + LW'(1);
          t1_nxt  = t0_r;
          t2_nxt  = t1_r;
        end
        OP_STAR: begin
          res[0] = mk_edge(n1, fa.start_st, 1'b1, '0);
          res[1] = mk_edge(n1, n2, 1'b1, '0);
          res[2] = mk_edge(fa.end_st, fa.start_st, 1'b1, '0);
          res[3] = mk_edge(fa.end_st, n2, 1'b1, '0);
          cnt    = RCNT_W'(4);
          top    = '{start_st: n1, end_st: n2};
        end
        OP_CONCAT: begin
          res[0]  = mk_edge(fa.end_st, fb.start_st, 1'b1, '0);
          cnt     = RCNT_W'(1);
          top     = '{start_st: fa.start_st, end_st: fb.end_st};
          lvl_new = level_r - LW'(1);
          t1_nxt  = t2_r;
          t2_load = 1'b1;
        end
        OP_UNION: begin
          res[0]  = mk_edge(n1, fa.start_st, 1'b1, '0);
          res[1]  = mk_edge(n1, fb.start_st, 1'b1, '0);
          res[2]  = mk_edge(fa.end_st, n2, 1'b1, '0);
          res[3]  = mk_edge(fb.end_st, n2, 1'b1, '0);
          cnt     = RCNT_W'(4);
          top     = '{start_st: n1, end_st: n2};
          lvl_new = level_r - LW'(1);
          t1_nxt  = t2_r;
          t2_load = 1'b1;
        end
      endcase
      t0_nxt    = top;
      wr_en     = 1'b1;
      level_nxt = lvl_new;
      if (head_data.end_of_expression) begin
        if (lvl_new == LW'(1)) begin
          res[cnt] = mk_done(top);
        end else begin
          res[cnt] = mk_err(ERR_LEFTOVER);
        end
        cnt       = cnt + RCNT_W'(1);
        level_nxt = '0;
        next_nxt  = '0;
      end
    end
    wr_addr = AW'(int'(lvl_new) - 1);
    res[cnt - RCNT_W'(1)].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      next_r  <= '0;
    end else if (take) begin
      level_r <= level_nxt;
      next_r  <= next_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      if (t2_load) begin
        if (rd_ok) begin
          t2_r <= mem[rd_addr];
        end
      end else begin
        t2_r <= t2_nxt;
      end
      if (wr_en) begin
        mem[wr_addr] <= t0_nxt;
      end
    end
  end

  `RNFA_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (level_r == '0) && (next_r == '0), "reset did not clear state")
  `RNFA_ASSERT(a_level_bound, clk, rst_n, level_r <= LW'(STACK_DEPTH), "stack level past depth")
  `RNFA_ASSERT(a_err_clears, clk, rst_n, take && (batch.res[0].result_kind == KIND_ERROR) |=> (level_r == '0) && (next_r == '0), "error did not clear state")
  `RNFA_ASSERT(a_cnt_range, clk, rst_n, take |-> (batch.cnt != '0) && (batch.cnt <= RCNT_W'(MAX_RES)), "bad result count")
  `RNFA_ASSERT(a_idle_hold, clk, rst_n, !take |=> $stable(level_r) && $stable(next_r), "state moved without a token")

endmodule

/* rtl/core/rnfa_out_q.sv */
// Result queue: holds one token's results and shifts them out a beat at a time.
// Depends on rnfa_pkg; fed by rnfa_core.
module rnfa_out_q (
  input  logic             clk,
  input  logic             rst_n,
  input  rnfa_pkg::batch_t batch,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output rnfa_pkg::out_t   out_data
);
  import rnfa_pkg::*;

  out_t              res_r [MAX_RES];
  logic [RCNT_W-1:0] cnt_r;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = res_r[0];
  assign pop       = out_valid && out_ready;
  assign load_ok   = (cnt_r == '0) || ((cnt_r == RCNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (batch.load) begin
      cnt_r <= batch.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - RCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (batch.load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= batch.res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

endmodule

/* rtl/core/regex_postfix_to_nfa_builder_unit.sv */
// Postfix regular expression to epsilon-NFA edge stream (Thompson construction).
// Depends on rnfa_pkg, rnfa_in_buf, rnfa_core and rnfa_out_q.
// Each token causes results that all leave on the one result port: one for a
// symbol or concatenation, four for a star or union, plus one for the done or
// leftover result on the last token; an error causes one. Tokens enter a
// two-entry queue, one per cycle while it is not full, and each token's stack
// update is registered when the token is taken, so consecutive tokens stream
// with no gaps between results. State numbers wrap modulo 256 on the outputs.
module regex_postfix_to_nfa_builder_unit #(
  parameter int STACK_DEPTH = 32,
  parameter int STATE_LIMIT = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rnfa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rnfa_pkg::out_t out_data
);
  import rnfa_pkg::*;

  logic   head_valid, head_take, load_ok;
  in_t    head_data;
  batch_t batch;

  rnfa_in_buf u_in_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_take  (head_take)
  );

  rnfa_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .STATE_LIMIT (STATE_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_take  (head_take),
    .load_ok    (load_ok),
    .batch      (batch)
  );

  rnfa_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
